// ----- design/sitda_pkg.sv -----
package sitda_pkg;

  // Input word and decimal digit geometry
  localparam int VALUE_W   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W     = 4 * NUM_DIGITS;
  localparam int CHAR_W    = 6;

  // ASCII codes, truncated to the character width
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Converted value handed from the converter to the character emitter
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } digits_t;

  // Double-dabble correction of one BCD digit ahead of a shift
  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    logic [3:0] r;
    if (d >= 4'd5) begin
      r = d + 4'd3;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ----- design/sitda_dabble.sv -----
module sitda_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sitda_pkg::VALUE_W-1:0] value,
  output logic                          dig_valid,
  input  logic                          dig_take,
  output sitda_pkg::digits_t            dig
);
  import sitda_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic               neg;
  logic [BCD_W-1:0]   bcd_adj;

  // Add-3 correction on every digit, independent per digit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dabble_adjust(bcd[4*i +: 4]);
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign dig_valid = (state == S_DONE);
  assign dig.neg   = neg;
  assign dig.bcd   = bcd;

  // One magnitude bit shifted into the BCD register per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg   <= value[VALUE_W-1];
            // 32-bit negate: the most negative value maps onto itself as unsigned
            mag   <= value[VALUE_W-1] ? (~value + {{(VALUE_W-1){1'b0}}, 1'b1}) : value;
            bcd   <= '0;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          {bcd, mag} <= {bcd_adj[BCD_W-2:0], mag, 1'b0};
          cnt        <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (dig_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/sitda_emit.sv -----
module sitda_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         dig_valid,
  output logic                         dig_take,
  input  sitda_pkg::digits_t           dig,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sitda_pkg::CHAR_W-1:0] character,
  output logic                         last_char
);
  import sitda_pkg::*;

  localparam int K_W = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIGN,
    S_DIGITS
  } state_t;

  state_t           state;
  logic [BCD_W-1:0] bcd;
  logic [K_W-1:0]   k;
  logic             started;
  logic [3:0]       top;
  logic             slot_free;
  logic             skip;
  logic             emit;

  assign top       = bcd[BCD_W-1 -: 4];
  assign slot_free = !out_valid || !out_stall;
  // leading zero, but never the units digit
  assign skip      = (top == 4'd0) && !started && (k != '0);
  assign dig_take  = (state == S_IDLE) && dig_valid;
  // a new character enters the output register this cycle
  assign emit      = slot_free && ((state == S_SIGN) || ((state == S_DIGITS) && !skip));

  // Digit walk, top digit first, into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
      k         <= '0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (dig_valid) begin
            bcd     <= dig.bcd;
            k       <= K_W'(NUM_DIGITS - 1);
            started <= 1'b0;
            state   <= dig.neg ? S_SIGN : S_DIGITS;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            character <= CHAR_MINUS;
            last_char <= 1'b0;
            state     <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (skip) begin
            bcd <= {bcd[BCD_W-5:0], 4'd0};
            k   <= k - 1'b1;
          end else if (slot_free) begin
            character <= CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top};
            last_char <= (k == '0);
            started   <= 1'b1;
            bcd       <= {bcd[BCD_W-5:0], 4'd0};
            k         <= k - 1'b1;
            if (k == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text.
// Input channel: in_valid / in_stall with the 32-bit two's complement value.
// Output channel: out_valid / out_stall, one character per beat, most
// significant first: '-' for negative values, then the digits with no
// leading zeros; last_char marks the final beat of each value's text.
// A value passes through the bit-serial binary-to-BCD converter (one
// magnitude bit per cycle), is handed off to the emitter, which walks
// the ten BCD digits top first: leading zeros are dropped one per cycle,
// other characters go out one per cycle while the receiver takes them.
// The converter works on the next value while the emitter still sends the
// previous text; the converter loop sets the pace of intake. Up to 11
// beats per value.
// A stalled character stays in the output register; the emitter holds and
// the converter holds its finished value, so in_stall rises in turn.
// Reset clears both control machines; no partial text survives it.
module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sitda_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]  character,
  output logic                          last_char
);
  import sitda_pkg::*;

  digits_t dig;
  logic    dig_valid;
  logic    dig_take;

  sitda_dabble u_dabble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .dig_valid (dig_valid),
    .dig_take  (dig_take),
    .dig       (dig)
  );

  sitda_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .dig_valid (dig_valid),
    .dig_take  (dig_take),
    .dig       (dig),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

endmodule

// ----- tb/decimal_text_checker.sv -----
module decimal_text_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [sitda_pkg::VALUE_W-1:0] value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [sitda_pkg::CHAR_W-1:0]  character,
  input  logic                          last_char,
  output int                            mismatch_count,
  output int                            pending
);
  import sitda_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } text_beat_t;

  // characters still owed by the block, oldest first
  text_beat_t expected_text_q[$];

  // Append the decimal text of one value: sign, then digits, most significant first
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W:0] mag;
    logic [3:0]       digits [NUM_DIGITS];
    int               ndig;
    text_beat_t       beat;
    // one extra bit so the most negative value has a valid magnitude
    mag  = v[VALUE_W-1] ? -{1'b1, v} : {1'b0, v};
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 10);
      mag          = mag / 10;
      ndig++;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      beat.character = CHAR_MINUS;
      beat.last_char = 1'b0;
      expected_text_q.push_back(beat);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      beat.character = CHAR_ZERO + CHAR_W'(digits[k]);
      beat.last_char = (k == 0);
      expected_text_q.push_back(beat);
    end
  endfunction

  // Predict on accepted input beats, compare on accepted output beats
  always @(posedge clk) begin
    text_beat_t want;
    if (rst) begin
      expected_text_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        push_decimal_text(value);
      end
      if (out_valid && !out_stall) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected beat: character %0d last_char %0d", character, last_char);
          mismatch_count++;
        end else begin
          want = expected_text_q.pop_front();
          if (character !== want.character) begin
            $error("character: expected %0d, actual %0d", want.character, character);
            mismatch_count++;
          end
          if (last_char !== want.last_char) begin
            $error("last_char: expected %0d, actual %0d", want.last_char, last_char);
            mismatch_count++;
          end
        end
      end
    end
    pending = expected_text_q.size();
  end

endmodule

// ----- tb/signed_int_to_decimal_ascii_tb.sv -----
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;
  localparam int NUM_CORNERS  = 22;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [VALUE_W-1:0] value    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  int mismatch_count;
  int pending;

  // no random idling on either side while set
  bit calm          = 1'b0;
  // receiver holds off once for a long stretch after this is set
  bit hold_off_req  = 1'b0;
  // set by the receiver once its hold-off is over
  bit hold_off_done = 1'b0;

  signed_int_to_decimal_ascii u_top (.*);

  decimal_text_checker u_checker (.*);

  always #4 clk = ~clk;

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  // Random idle cycles, then offer one beat and hold it until taken
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!calm && ($urandom_range(99) < 29)) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering until every owed character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Mix of full-range words, short numbers and decimal boundaries
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    logic [VALUE_W-1:0] v;
    int                 k;
    p = 1;
    k = $urandom_range(9);
    for (int i = 0; i < k; i++) begin
      p = p * 10;
    end
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: v = p - $urandom_range(1);
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) begin
      v = -v;
    end
    return v;
  endfunction

  // Stimulus and verdict
  initial begin
    logic [VALUE_W-1:0] corners [NUM_CORNERS];
    corners = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                32'd999999999, 32'd1234567890, -32'sd1000000000, -32'sd999999999,
                32'h5555_5555, 32'hAAAA_AAAA, 32'd5, -32'sd5, 32'd2147483640,
                -32'sd9};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    for (int i = 0; i < NUM_CORNERS; i++) begin
      send_value(corners[i]);
    end
    wait_drained();

    // stretch with no idling on either side
    calm = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_value(pick_value());
    end

    // receiver holds off while the sender keeps offering beats
    hold_off_req = 1'b1;
    for (int i = 0; i < 15; i++) begin
      send_value(pick_value());
    end
    calm = 1'b0;
    wait_drained();

    // random bulk, with a full drain now and then
    for (int i = 0; i < 295; i++) begin
      send_value(pick_value());
      if (i % 100 == 99) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii_tb passed");
    end else begin
      $display("signed_int_to_decimal_ascii_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("signed_int_to_decimal_ascii_tb failed");
    $finish;
  end

endmodule
